FILE: rtl/asp_pkg.sv
// Shared constants and types for the atlas shelf packer.
package asp_pkg;

  localparam int AtlasSize  = 1024;
  localparam int MaxShelves = 64;
  localparam int CellGap    = 1;

  localparam int CoordW = $clog2(AtlasSize);
  localparam int DimW   = CoordW + 1;
  localparam int IdxW   = (MaxShelves > 1) ? $clog2(MaxShelves) : 1;
  localparam int CountW = $clog2(MaxShelves + 1);

  localparam logic [DimW:0]     AtlasLim   = (DimW + 1)'(AtlasSize);
  localparam logic [DimW:0]     GapW       = (DimW + 1)'(CellGap);
  localparam logic [CountW-1:0] ShelfLimit = CountW'(MaxShelves);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic [CoordW-1:0] top;
    logic [DimW-1:0]   height;
    logic [DimW-1:0]   fill;
  } shelf_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic do_clear;
    logic reject;
    logic scan_start;
    logic scan_next;
    logic hit_commit;
    logic new_commit;
    logic load_out;
  } asp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic is_bad;
    logic count_zero;
    logic hit;
    logic last;
  } asp_stat_t;

endpackage

FILE: rtl/asp_ctrl.sv
// Controller state machine of the atlas shelf packer.
module asp_ctrl
  import asp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  asp_stat_t stat_i,
  output asp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_NEW    = 5'b01000,
    ST_DONE   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_clear) begin
          cmd_o.do_clear = 1'b1;
          state_d        = ST_DONE;
        end else if (stat_i.is_bad) begin
          cmd_o.reject = 1'b1;
          state_d      = ST_DONE;
        end else if (stat_i.count_zero) begin
          state_d = ST_NEW;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.hit_commit = 1'b1;
          state_d          = ST_DONE;
        end else if (stat_i.last) begin
          state_d = ST_NEW;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_NEW: begin
        cmd_o.new_commit = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/asp_dpath.sv
// Datapath of the atlas shelf packer: shelf memory, scan compare and result registers.
module asp_dpath
  import asp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              operation_i,
  input  logic [DimW-1:0]   box_width_i,
  input  logic [DimW-1:0]   box_height_i,
  input  asp_cmd_t          cmd_i,
  output asp_stat_t         stat_o,
  output logic              placed_o,
  output logic [CoordW-1:0] place_x_o,
  output logic [CoordW-1:0] place_y_o,
  output logic              atlas_full_o
);

  shelf_t mem_q [MaxShelves];
  shelf_t rd_q;

  op_e               op_q;
  logic [DimW-1:0]   bw_q, bh_q;
  logic [CountW-1:0] count_q, count_d;
  logic              full_q, full_d;
  logic [DimW-1:0]   last_bot_q, last_bot_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   chk_q, chk_d;

  logic              res_placed_q, res_placed_d;
  logic [CoordW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic              out_placed_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              out_full_q;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  shelf_t            wr_data;

  logic [DimW-1:0]   next_y;
  logic [DimW:0]     new_bottom;
  logic              new_fits;
  logic [DimW:0]     hit_end;

  assign hit_end    = {1'b0, rd_q.fill} + {1'b0, bw_q};
  assign next_y     = (count_q == '0) ? '0 : last_bot_q;
  assign new_bottom = {1'b0, next_y} + {1'b0, bh_q};
  assign new_fits   = (count_q != ShelfLimit) && (new_bottom <= AtlasLim);

  always_comb begin
    stat_o.is_clear   = (op_q == OP_CLEAR);
    stat_o.is_bad     = (bw_q == '0) || (bh_q == '0) || ({1'b0, bw_q} > AtlasLim);
    stat_o.count_zero = (count_q == '0);
    stat_o.hit        = (rd_q.height >= bh_q) && (hit_end <= AtlasLim);
    stat_o.last       = (CountW'(chk_q) == count_q - CountW'(1));
  end

  always_comb begin
    count_d      = count_q;
    full_d       = full_q;
    last_bot_d   = last_bot_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    res_placed_d = res_placed_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    wr_en        = 1'b0;
    wr_addr      = chk_q;
    wr_data      = rd_q;

    if (cmd_i.latch_in) begin
      // Shelf 0 is read on the decode cycle, so the scan sees it at once.
      idx_d = '0;
    end
    if (cmd_i.do_clear) begin
      count_d      = '0;
      full_d       = 1'b0;
      res_placed_d = 1'b0;
      res_x_d      = '0;
      res_y_d      = '0;
    end
    if (cmd_i.reject) begin
      res_placed_d = 1'b0;
      res_x_d      = '0;
      res_y_d      = '0;
    end
    if (cmd_i.scan_start || cmd_i.scan_next) begin
      chk_d = idx_q;
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_i.hit_commit) begin
      wr_en        = 1'b1;
      wr_addr      = chk_q;
      wr_data.fill = DimW'(hit_end + GapW);
      res_placed_d = 1'b1;
      res_x_d      = CoordW'(rd_q.fill);
      res_y_d      = rd_q.top;
    end
    if (cmd_i.new_commit) begin
      if (new_fits) begin
        wr_en          = 1'b1;
        wr_addr        = IdxW'(count_q);
        wr_data.top    = CoordW'(next_y);
        wr_data.height = bh_q;
        wr_data.fill   = DimW'({1'b0, bw_q} + GapW);
        count_d        = count_q + CountW'(1);
        last_bot_d     = DimW'(new_bottom + GapW);
        res_placed_d   = 1'b1;
        res_x_d        = '0;
        res_y_d        = CoordW'(next_y);
      end else begin
        full_d       = 1'b1;
        res_placed_d = 1'b0;
        res_x_d      = '0;
        res_y_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      full_q  <= 1'b0;
      idx_q   <= '0;
      chk_q   <= '0;
    end else begin
      count_q <= count_d;
      full_q  <= full_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q <= op_e'(operation_i);
      bw_q <= box_width_i;
      bh_q <= box_height_i;
    end
    last_bot_q   <= last_bot_d;
    res_placed_q <= res_placed_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    if (cmd_i.load_out) begin
      out_placed_q <= res_placed_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_full_q   <= full_q;
    end
  end

  assign placed_o     = out_placed_q;
  assign place_x_o    = out_x_q;
  assign place_y_o    = out_y_q;
  assign atlas_full_o = out_full_q;

endmodule

FILE: rtl/atlas_shelf_packer_core.sv
// Top level of the atlas shelf packer: controller, datapath and assertions.
// Latency: an allocate is decoded, scans the open shelves in order and, if none fits, opens a
// new shelf; a clear or a rejected request goes from decode straight to the done state.
// Throughput: one word at a time, set by the shelf memory read port, which serves one
// shelf per cycle during the scan.
// Reset: asynchronous, active low; clears shelf count, full flag and control state.
module atlas_shelf_packer_core
  import asp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [DimW-1:0]   box_width_i,
  input  logic [DimW-1:0]   box_height_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              placed_o,
  output logic [CoordW-1:0] place_x_o,
  output logic [CoordW-1:0] place_y_o,
  output logic              atlas_full_o
);

  asp_cmd_t  cmd;
  asp_stat_t stat;

  asp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  asp_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (operation_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .placed_o     (placed_o),
    .place_x_o    (place_x_o),
    .place_y_o    (place_y_o),
    .atlas_full_o (atlas_full_o)
  );

`ifndef SYNTH
  // Once a word is taken the block is busy on the following cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("output word overwritten while stalled");

  // A request that was not placed reports the origin.
  a_unplaced_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !placed_o) |-> (place_x_o == '0 && place_y_o == '0))
    else $error("unplaced result carries a position");

  // At most one state-changing action per cycle.
  a_single_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.do_clear, cmd.reject, cmd.hit_commit, cmd.new_commit, cmd.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule
